FILE: design/brt_pkg.sv
// brt_pkg: shared types and constants for the button press / LED ramp timer.
// No dependencies; used by the interfaces, brt_step and the top level.
`timescale 1ns / 1ps
`default_nettype none

package brt_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RAMP_INTERVAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_HOLD_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ON_TIME_RELOAD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_DUTY       = 3'd5;

  localparam logic [1:0] MODE_WAITING   = 2'd0;
  localparam logic [1:0] MODE_RUNNING   = 2'd1;
  localparam logic [1:0] MODE_TIMERLESS = 2'd2;
  localparam logic [1:0] MODE_ALWAYS_ON = 2'd3;

  localparam logic [15:0] CNT16_MAX = 16'hFFFF;
  localparam logic [7:0]  CNT8_MAX  = 8'hFF;

  typedef struct packed {
    logic [7:0]  ramp_interval;
    logic [15:0] debounce_ticks;
    logic [15:0] hold_ticks;
    logic [15:0] mode_hold_ticks;
    logic [15:0] on_time_reload;
    logic [7:0]  full_duty;
  } cfg_t;

  typedef struct packed {
    logic        button_level;
    logic [1:0]  current_mode;
    logic        load_target;
    logic [7:0]  target_value;
    logic        restart_timer;
    logic        clear_fresh;
    logic        clear_quick;
  } item_t;

  typedef struct packed {
    logic        edge_armed;
    logic        prev_level;
    logic [15:0] stable_count;
    logic [7:0]  ramp_count;
    logic [7:0]  duty_now;
    logic [7:0]  duty_goal;
    logic        fresh_flag;
    logic        quick_flag;
    logic        long_armed;
    logic [15:0] countdown;
  } state_t;

  typedef struct packed {
    logic [7:0]  duty;
    logic        fresh_press;
    logic        quick_press;
    logic        mode_change_valid;
    logic [1:0]  new_mode;
    logic        toggle_request;
    logic [15:0] time_left;
  } result_t;

endpackage

`default_nettype wire

FILE: design/brt_if.sv
// Channel interfaces: tick requests in, results out, configuration writes.
// Depends on brt_pkg for the config port widths.
`timescale 1ns / 1ps
`default_nettype none

interface brt_tick_if;
  logic       valid;
  logic       ready;
  logic       button_level;
  logic [1:0] current_mode;
  logic       load_target;
  logic [7:0] target_value;
  logic       restart_timer;
  logic       clear_fresh;
  logic       clear_quick;

  modport source (output valid, button_level, current_mode, load_target, target_value,
                  restart_timer, clear_fresh, clear_quick, input ready);
  modport sink (input valid, button_level, current_mode, load_target, target_value,
                restart_timer, clear_fresh, clear_quick, output ready);
endinterface

interface brt_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  duty;
  logic        fresh_press;
  logic        quick_press;
  logic        mode_change_valid;
  logic [1:0]  new_mode;
  logic        toggle_request;
  logic [15:0] time_left;

  modport source (output valid, duty, fresh_press, quick_press, mode_change_valid,
                  new_mode, toggle_request, time_left, input ready);
  modport sink (input valid, duty, fresh_press, quick_press, mode_change_valid,
                new_mode, toggle_request, time_left, output ready);
endinterface

interface brt_cfg_if
  import brt_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/brt_step.sv
// brt_step: next-state and result logic for one tick.
// Purely combinational; depends on brt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brt_step
  import brt_pkg::*;
(
  input  cfg_t    cfg,
  input  state_t  st,
  input  item_t   item,
  output state_t  st_next,
  output result_t res
);

  logic       lvl;
  logic       fresh0, quick0, fresh1, quick1, fresh2;
  logic       armed1;
  logic       long1, long2;
  logic [7:0] goal0, goal1;
  logic [15:0] cd0, cd1;
  logic [15:0] stable1;
  logic [7:0] rc_inc, rc1;
  logic [7:0] duty1, duty2;
  logic       forced;
  logic       running;
  logic       timeout;
  logic       toggle;

  always_comb begin
    lvl    = item.button_level;
    fresh0 = item.clear_fresh ? 1'b0 : st.fresh_flag;
    quick0 = item.clear_quick ? 1'b0 : st.quick_flag;
    goal0  = item.load_target ? item.target_value : st.duty_goal;
    cd0    = item.restart_timer ? cfg.on_time_reload : st.countdown;

    // debounce and press latch
    fresh1 = fresh0;
    armed1 = st.edge_armed;
    if (st.edge_armed && !lvl) begin
      fresh1 = 1'b1;
      armed1 = 1'b0;
    end
    if (lvl == st.prev_level) begin
      stable1 = (st.stable_count != CNT16_MAX) ? st.stable_count + 16'd1 : st.stable_count;
    end else begin
      stable1 = '0;
    end
    long1 = st.long_armed;
    if (stable1 > cfg.debounce_ticks && lvl) begin
      armed1 = 1'b1;
      long1  = 1'b1;
    end

    // ramp
    rc_inc = (st.ramp_count != CNT8_MAX) ? st.ramp_count + 8'd1 : st.ramp_count;
    rc1    = rc_inc;
    duty1  = st.duty_now;
    if (rc_inc >= cfg.ramp_interval && st.duty_now != goal0) begin
      duty1 = (st.duty_now < goal0) ? st.duty_now + 8'd1 : st.duty_now - 8'd1;
      rc1   = '0;
    end

    // quick press / long hold
    fresh2 = fresh1;
    quick1 = quick0;
    forced = 1'b0;
    if (fresh1) begin
      if (lvl) begin
        quick1 = 1'b1;
        fresh2 = 1'b0;
      end else if (stable1 > cfg.hold_ticks) begin
        fresh2 = 1'b0;
        forced = (item.current_mode != MODE_ALWAYS_ON);
      end
    end
    goal1 = forced ? cfg.full_duty : goal0;
    duty2 = forced ? cfg.full_duty : duty1;

    // countdown
    running = !forced && (item.current_mode == MODE_RUNNING);
    cd1     = running ? cd0 - 16'd1 : cd0;
    timeout = running && (cd1 == '0);
    if (timeout) begin
      goal1 = '0;
    end

    // control-mode toggle
    toggle = !lvl && (stable1 > cfg.mode_hold_ticks) && long1;
    long2  = toggle ? 1'b0 : long1;
    if (toggle) begin
      quick1 = 1'b0;
    end

    st_next.edge_armed   = armed1;
    st_next.prev_level   = lvl;
    st_next.stable_count = stable1;
    st_next.ramp_count   = rc1;
    st_next.duty_now     = duty2;
    st_next.duty_goal    = goal1;
    st_next.fresh_flag   = fresh2;
    st_next.quick_flag   = quick1;
    st_next.long_armed   = long2;
    st_next.countdown    = cd1;

    res.duty              = duty2;
    res.fresh_press       = fresh2;
    res.quick_press       = quick1;
    res.mode_change_valid = forced || timeout;
    res.new_mode          = forced ? MODE_TIMERLESS : MODE_WAITING;
    res.toggle_request    = toggle;
    res.time_left         = cd1;
  end

endmodule

`default_nettype wire

FILE: design/button_press_led_ramp_timer.sv
// button_press_led_ramp_timer: top level, config registers, state and result register.
// Depends on brt_pkg, brt_if.sv (channel interfaces) and brt_step.
//
//   channel | dir | payload
//   tick    | in  | button_level, current_mode, load_target, target_value,
//           |     | restart_timer, clear_fresh, clear_quick
//   result  | out | duty, fresh_press, quick_press, mode_change_valid,
//           |     | new_mode, toggle_request, time_left
//   cfg     | in  | index (register number), data
//
// One tick request per cycle while tick.ready is high; its result is registered
// in the cycle after acceptance. The state update is a single pass through brt_step.
// tick.ready is low only while a result is held and result.ready is low.
// cfg is always ready. Synchronous rst restores cfg_reg, st and res_valid; not res_reg.
`timescale 1ns / 1ps
`default_nettype none

module button_press_led_ramp_timer
  import brt_pkg::*;
(
  input  wire           clk,
  input  wire           rst,
  brt_tick_if.sink      tick,
  brt_result_if.source  result,
  brt_cfg_if.sink       cfg
);

  cfg_t    cfg_reg;
  state_t  st;
  state_t  st_next;
  item_t   item;
  result_t res;
  result_t res_reg;
  logic    res_valid;
  logic    tick_acc;

  assign tick.ready = !res_valid || result.ready;
  assign tick_acc   = tick.valid && tick.ready;
  assign cfg.ready  = 1'b1;

  always_comb begin
    item.button_level  = tick.button_level;
    item.current_mode  = tick.current_mode;
    item.load_target   = tick.load_target;
    item.target_value  = tick.target_value;
    item.restart_timer = tick.restart_timer;
    item.clear_fresh   = tick.clear_fresh;
    item.clear_quick   = tick.clear_quick;
  end

  brt_step u_step (
    .cfg     (cfg_reg),
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.ramp_interval   <= 8'd2;
      cfg_reg.debounce_ticks  <= 16'd10;
      cfg_reg.hold_ticks      <= 16'd200;
      cfg_reg.mode_hold_ticks <= 16'd800;
      cfg_reg.on_time_reload  <= 16'd60000;
      cfg_reg.full_duty       <= 8'd255;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_RAMP_INTERVAL:   cfg_reg.ramp_interval   <= cfg.data[7:0];
        REG_DEBOUNCE_TICKS:  cfg_reg.debounce_ticks  <= cfg.data;
        REG_HOLD_TICKS:      cfg_reg.hold_ticks      <= cfg.data;
        REG_MODE_HOLD_TICKS: cfg_reg.mode_hold_ticks <= cfg.data;
        REG_ON_TIME_RELOAD:  cfg_reg.on_time_reload  <= cfg.data;
        REG_FULL_DUTY:       cfg_reg.full_duty       <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.edge_armed   <= 1'b0;
      st.prev_level   <= 1'b1;
      st.stable_count <= '0;
      st.ramp_count   <= '0;
      st.duty_now     <= '0;
      st.duty_goal    <= '0;
      st.fresh_flag   <= 1'b0;
      st.quick_flag   <= 1'b0;
      st.long_armed   <= 1'b1;
      st.countdown    <= '0;
      res_valid       <= 1'b0;
    end else begin
      if (tick_acc) begin
        st <= st_next;
      end
      if (tick_acc) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      res_reg <= res;
    end
  end

  assign result.valid             = res_valid;
  assign result.duty              = res_reg.duty;
  assign result.fresh_press       = res_reg.fresh_press;
  assign result.quick_press       = res_reg.quick_press;
  assign result.mode_change_valid = res_reg.mode_change_valid;
  assign result.new_mode          = res_reg.new_mode;
  assign result.toggle_request    = res_reg.toggle_request;
  assign result.time_left         = res_reg.time_left;

  a_drain: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready && !tick_acc |=> !result.valid)
    else $error("result held after being taken");

  a_toggle_disarm: assert property (@(posedge clk) disable iff (rst)
    tick_acc && res.toggle_request |=> !st.long_armed && !result.quick_press)
    else $error("toggle did not disarm long hold");

  a_forced_duty: assert property (@(posedge clk) disable iff (rst)
    tick_acc && res.mode_change_valid && res.new_mode == MODE_TIMERLESS
      |=> result.duty == $past(cfg_reg.full_duty) && st.duty_goal == result.duty)
    else $error("forced timerless without full duty");

  a_duty_track: assert property (@(posedge clk) disable iff (rst)
    tick_acc |=> result.duty == st.duty_now && result.time_left == st.countdown)
    else $error("result out of step with state");

endmodule

`default_nettype wire
